[hdl/epr_pkg.sv]
// Shared types, constants and the pan gain table for the envelope pan ramp setup block.
// Used by epr_cell and by the top level envelope_pan_ramp_setup_core.
package epr_pkg;

    localparam int PAN_TABLE_LENGTH = 128;
    localparam int PAN_W            = $clog2(PAN_TABLE_LENGTH);
    localparam int LEVEL_W          = 15;
    localparam int LEN_W            = 24;
    localparam int MAG_W            = 19;
    localparam int RATE_W           = 16;
    localparam int INT_STEPS        = MAG_W;
    localparam int FRAC_STEPS       = RATE_W;

    localparam logic [PAN_W-1:0]  PAN_CENTER = PAN_W'(PAN_TABLE_LENGTH / 2);
    localparam logic [RATE_W-1:0] INT_MAX    = 16'h7FFF;
    localparam logic [RATE_W-1:0] INT_MIN    = 16'h8000;
    localparam logic [RATE_W-1:0] FRAC_FULL  = 16'hFFFF;

    localparam logic [LEVEL_W-1:0] PAN_GAIN [PAN_TABLE_LENGTH] = '{
        15'd32767, 15'd32764, 15'd32757, 15'd32744, 15'd32727, 15'd32704, 15'd32677, 15'd32644,
        15'd32607, 15'd32564, 15'd32517, 15'd32464, 15'd32407, 15'd32344, 15'd32277, 15'd32205,
        15'd32127, 15'd32045, 15'd31958, 15'd31866, 15'd31770, 15'd31668, 15'd31561, 15'd31450,
        15'd31334, 15'd31213, 15'd31087, 15'd30957, 15'd30822, 15'd30682, 15'd30537, 15'd30388,
        15'd30234, 15'd30075, 15'd29912, 15'd29744, 15'd29572, 15'd29395, 15'd29214, 15'd29028,
        15'd28838, 15'd28643, 15'd28444, 15'd28241, 15'd28033, 15'd27821, 15'd27605, 15'd27385,
        15'd27160, 15'd26931, 15'd26698, 15'd26461, 15'd26220, 15'd25975, 15'd25726, 15'd25473,
        15'd25216, 15'd24956, 15'd24691, 15'd24423, 15'd24151, 15'd23875, 15'd23596, 15'd23313,
        15'd23026, 15'd22736, 15'd22442, 15'd22145, 15'd21845, 15'd21541, 15'd21234, 15'd20924,
        15'd20610, 15'd20294, 15'd19974, 15'd19651, 15'd19325, 15'd18997, 15'd18665, 15'd18331,
        15'd17993, 15'd17653, 15'd17310, 15'd16965, 15'd16617, 15'd16266, 15'd15913, 15'd15558,
        15'd15200, 15'd14840, 15'd14477, 15'd14113, 15'd13746, 15'd13377, 15'd13006, 15'd12633,
        15'd12258, 15'd11881, 15'd11503, 15'd11122, 15'd10740, 15'd10357, 15'd9971,  15'd9584,
        15'd9196,  15'd8806,  15'd8415,  15'd8023,  15'd7630,  15'd7235,  15'd6839,  15'd6442,
        15'd6044,  15'd5646,  15'd5246,  15'd4845,  15'd4444,  15'd4042,  15'd3640,  15'd3237,
        15'd2833,  15'd2429,  15'd2025,  15'd1620,  15'd1216,  15'd810,   15'd405,   15'd0
    };

    // One side's ramp computation as it moves along the divider cells.
    typedef struct packed {
        logic [LEN_W-1:0]   rem;     // partial remainder, below den when the length is nonzero
        logic [MAG_W-1:0]   acc;     // dividend bits still to enter, quotient bits behind
        logic [LEN_W-1:0]   den;     // segment length
        logic [LEVEL_W-1:0] tgt;     // panned target level
        logic               neg;     // rate numerator is negative
        logic               zl;      // segment length is zero
        logic               zl_up;   // target at or above current level
        logic               sat_hi;  // floor above the integer range
        logic               sat_lo;  // floor below the integer range
        logic [RATE_W-1:0]  qi;      // integer part of the rate
    } side_t;

endpackage

[hdl/epr_cell.sv]
// One restoring-division cell: a single quotient bit per cycle while en is high, for one side.
// Depends on epr_pkg for side_t.
module epr_cell (
    input  logic           aclk,
    input  logic           en,
    input  epr_pkg::side_t side_in,
    output epr_pkg::side_t side_out
);

    epr_pkg::side_t         side_reg, side_next;
    logic [epr_pkg::LEN_W:0] trial;
    logic                    fits;

    always_comb begin
        trial = {side_in.rem, side_in.acc[epr_pkg::MAG_W-1]};
        fits  = (trial >= {1'b0, side_in.den});
        side_next = side_in;
        side_next.rem = fits ? epr_pkg::LEN_W'(trial - {1'b0, side_in.den})
                             : trial[epr_pkg::LEN_W-1:0];
        side_next.acc = {side_in.acc[epr_pkg::MAG_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
        end
    end

    assign side_out = side_reg;

endmodule

[hdl/envelope_pan_ramp_setup_core.sv]
// Top level of the envelope pan ramp setup block: pan stage, divider cell chains, output register.
// Depends on epr_pkg and epr_cell.
//
// Usage: each transfer on the s_ channel carries one voice's volume, pan position,
// current left and right envelope levels and segment length. For every input
// transfer exactly one result transfer leaves on the m_ channel with the panned
// left and right targets and each side's ramp rate (floor integer part and a
// 16-bit fraction scaled by 65535).
// The cfg channel writes the stereo enable bit; it is always ready and should be
// written only while no voice is in flight.
// From input transfer to m_tvalid a voice passes the register for the pan
// table and multiply, the one for the rate numerator, 19 divider cells for the
// integer quotient, the floor correction register, 16 divider cells for the
// fraction and the output register. One voice is accepted every cycle while the
// output is not stalled; the chain of divider cells, each retiring one quotient bit, sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; it returns as soon as m_tready is seen.
// Reset clears every valid bit and sets stereo enable to mono; payload
// registers keep whatever they held.
module envelope_pan_ramp_setup_core (
    input  logic        aclk,
    input  logic        aresetn,
    // volume[14:0], pan[21:15], current_left[37:22], current_right[53:38],
    // segment_length[77:54], zeros[79:78]
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_target[14:0], right_target[29:15], left_rate_int[45:30],
    // left_rate_frac[61:46], right_rate_int[77:62], right_rate_frac[93:78], zeros[95:94]
    output logic [95:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    localparam int NSTG = 3 + epr_pkg::INT_STEPS + epr_pkg::FRAC_STEPS;
    localparam int S3   = 2 + epr_pkg::INT_STEPS;

    logic en;
    logic stereo_reg;
    logic [NSTG-1:0] v_reg;
    logic m_tvalid_reg;

    // Input field unpacking.
    logic [14:0] in_vol;
    logic [6:0]  in_pan;
    logic [15:0] in_cur_l, in_cur_r;
    logic [23:0] in_len;

    assign in_vol   = s_tdata[14:0];
    assign in_pan   = s_tdata[21:15];
    assign in_cur_l = s_tdata[37:22];
    assign in_cur_r = s_tdata[53:38];
    assign in_len   = s_tdata[77:54];

    // The pipeline moves as one: it advances whenever the output register is free.
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stereo_reg <= 1'b0;
        end else if (cfg_valid) begin
            stereo_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v_reg        <= {v_reg[NSTG-2:0], s_tvalid};
            m_tvalid_reg <= v_reg[NSTG-1];
        end
    end

    // Stage 1: table lookup and volume multiply per side.
    logic [epr_pkg::PAN_W-1:0] idx_l, idx_r;
    logic [29:0] prod_l_reg, prod_r_reg;
    logic [15:0] cur_l_reg, cur_r_reg;
    logic [23:0] len_reg;

    assign idx_l = stereo_reg ? in_pan  : epr_pkg::PAN_CENTER;
    assign idx_r = stereo_reg ? ~in_pan : epr_pkg::PAN_CENTER;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_l_reg <= in_vol * epr_pkg::PAN_GAIN[idx_l];
            prod_r_reg <= in_vol * epr_pkg::PAN_GAIN[idx_r];
            cur_l_reg  <= in_cur_l;
            cur_r_reg  <= in_cur_r;
            len_reg    <= in_len;
        end
    end

    // Stage 2: clamp the levels and form the magnitude of 8*(target - current).
    function automatic epr_pkg::side_t prep(input logic [14:0] tgt, input logic [15:0] cur,
                                            input logic [23:0] len);
        epr_pkg::side_t   s;
        logic [14:0]      tc, cc;
        logic signed [16:0] diff;
        logic [19:0]      num;
        s     = '0;
        tc    = (tgt == 15'd0) ? 15'd1 : tgt;
        cc    = ($signed(cur) <= 16'sd0) ? 15'd1 : cur[14:0];
        diff  = $signed({2'b00, tc}) - $signed({2'b00, cc});
        num   = {diff[16:0], 3'b000};
        s.neg = diff[16];
        s.acc = s.neg ? epr_pkg::MAG_W'(-num) : num[epr_pkg::MAG_W-1:0];
        s.den = len;
        s.tgt = tgt;
        s.zl  = (len == 24'd0);
        s.zl_up = ($signed({2'b00, tgt}) >= $signed({cur[15], cur}));
        return s;
    endfunction

    epr_pkg::side_t a_l [epr_pkg::INT_STEPS+1];
    epr_pkg::side_t a_r [epr_pkg::INT_STEPS+1];
    epr_pkg::side_t b_l [epr_pkg::FRAC_STEPS+1];
    epr_pkg::side_t b_r [epr_pkg::FRAC_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_l[0] <= prep(prod_l_reg[29:15], cur_l_reg, len_reg);
            a_r[0] <= prep(prod_r_reg[29:15], cur_r_reg, len_reg);
        end
    end

    // Integer quotient: one bit per cell.
    for (genvar i = 0; i < epr_pkg::INT_STEPS; i++) begin : g_int
        epr_cell u_cl (.aclk(aclk), .en(en), .side_in(a_l[i]), .side_out(a_l[i+1]));
        epr_cell u_cr (.aclk(aclk), .en(en), .side_in(a_r[i]), .side_out(a_r[i+1]));
    end

    // Floor correction, saturation flags and the scaled remainder for the fraction.
    function automatic epr_pkg::side_t fix(input epr_pkg::side_t s);
        epr_pkg::side_t o;
        logic [18:0] qa;
        logic [19:0] qmag;
        logic        rnz;
        logic [23:0] r;
        logic [39:0] n;
        o    = s;
        qa   = s.acc;
        rnz  = (s.rem != 24'd0);
        qmag = {1'b0, qa} + {19'd0, s.neg & rnz};
        r    = s.neg ? (rnz ? s.den - s.rem : 24'd0) : s.rem;
        n    = {r, 16'd0} - {16'd0, r};
        o.sat_hi = !s.neg && (qa > 19'd32767);
        o.sat_lo = s.neg && (qmag > 20'd32768);
        o.qi     = s.neg ? 16'(-qmag) : qa[15:0];
        o.rem    = n[39:16];
        o.acc    = {n[15:0], 3'b000};
        return o;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            b_l[0] <= fix(a_l[epr_pkg::INT_STEPS]);
            b_r[0] <= fix(a_r[epr_pkg::INT_STEPS]);
        end
    end

    for (genvar j = 0; j < epr_pkg::FRAC_STEPS; j++) begin : g_frac
        epr_cell u_fl (.aclk(aclk), .en(en), .side_in(b_l[j]), .side_out(b_l[j+1]));
        epr_cell u_fr (.aclk(aclk), .en(en), .side_in(b_r[j]), .side_out(b_r[j+1]));
    end

    // Final selection of the special cases into the output register.
    function automatic logic [31:0] rate(input epr_pkg::side_t s);
        if (s.zl) begin
            return s.zl_up ? {epr_pkg::FRAC_FULL, epr_pkg::INT_MAX} : 32'd0;
        end else if (s.sat_hi) begin
            return {epr_pkg::FRAC_FULL, epr_pkg::INT_MAX};
        end else if (s.sat_lo) begin
            return {16'd0, epr_pkg::INT_MIN};
        end
        return {s.acc[15:0], s.qi};
    endfunction

    logic [95:0] m_tdata_reg;
    epr_pkg::side_t fl, fr;
    assign fl = b_l[epr_pkg::FRAC_STEPS];
    assign fr = b_r[epr_pkg::FRAC_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {2'b00, rate(fr), rate(fl), fr.tgt, fl.tgt};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // An accepted voice always lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted voice missing from first stage");

    // After the floor correction the remainder fed to the fraction stays below the length.
    a_frac_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[S3] && !b_l[0].zl |-> (b_l[0].rem < b_l[0].den))
        else $error("fraction remainder not below segment length");

    // A stall freezes the last divider stage so the waiting voice is not lost.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(fl) && $stable(fr) && $stable(v_reg))
        else $error("pipeline moved during stall");

    // In mono both sides carry the same target.
    a_mono_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[1] && !stereo_reg && $stable(stereo_reg) && $past(en)
        |-> (a_l[0].tgt == a_r[0].tgt) || $past(stereo_reg, 2))
        else $error("mono targets differ");

endmodule

[sim/envelope_pan_ramp_setup_core_test.sv]
// Self-checking testbench for envelope_pan_ramp_setup_core: panned targets and ramp rates.
// Depends on epr_pkg and the RTL of the block; predicts every result in integer arithmetic.
`timescale 1ns / 1ps
module envelope_pan_ramp_setup_core_test;

    typedef struct packed {
        logic [23:0] seg_len;
        logic [15:0] cur_r;
        logic [15:0] cur_l;
        logic [6:0]  pan;
        logic [14:0] volume;
    } voice_t;

    typedef struct packed {
        logic [15:0] r_frac;
        logic [15:0] r_int;
        logic [15:0] l_frac;
        logic [15:0] l_int;
        logic [14:0] r_tgt;
        logic [14:0] l_tgt;
    } ramp_t;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [79:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_data = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    envelope_pan_ramp_setup_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    voice_t pending_voices[$];
    ramp_t  expected_ramps[$];
    logic   stereo_mode = 1'b0;
    int     errors = 0;
    int     voices_sent = 0;
    int     ramps_seen = 0;
    int     idle_cycles = 0;
    int     send_gap = 0;
    int     recv_gap = 0;

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Floor of 8*(target-current)/length split into a saturated integer
    // part and a fraction scaled by 65535.
    function automatic void ramp_of(input logic signed [15:0] cur, input logic [14:0] tgt,
                                    input logic [23:0] seg, output logic [15:0] ri,
                                    output logic [15:0] rf);
        longint t, c, num, den, q, r;
        t = tgt;
        c = cur;
        if (seg == 0) begin
            // A zero length jumps immediately; the compare uses raw levels.
            ri = (t >= c) ? epr_pkg::INT_MAX : 16'h0000;
            rf = (t >= c) ? epr_pkg::FRAC_FULL : 16'h0000;
            return;
        end
        if (t < 1) t = 1;
        if (c <= 0) c = 1;
        num = 8 * (t - c);
        den = seg;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        r = num - q * den;
        if (q > 32767) begin
            ri = epr_pkg::INT_MAX;
            rf = epr_pkg::FRAC_FULL;
        end else if (q < -32768) begin
            ri = epr_pkg::INT_MIN;
            rf = 16'h0000;
        end else begin
            ri = q[15:0];
            rf = 16'((r * 65535) / den);
        end
    endfunction

    function automatic ramp_t voice_ramp(input voice_t v, input logic stereo);
        ramp_t res;
        int    li, ri;
        li = stereo ? int'(v.pan) : epr_pkg::PAN_TABLE_LENGTH / 2;
        ri = stereo ? epr_pkg::PAN_TABLE_LENGTH - 1 - int'(v.pan)
                    : epr_pkg::PAN_TABLE_LENGTH / 2;
        res.l_tgt = 15'((longint'(v.volume) * epr_pkg::PAN_GAIN[li]) >> 15);
        res.r_tgt = 15'((longint'(v.volume) * epr_pkg::PAN_GAIN[ri]) >> 15);
        ramp_of(v.cur_l, res.l_tgt, v.seg_len, res.l_int, res.l_frac);
        ramp_of(v.cur_r, res.r_tgt, v.seg_len, res.r_int, res.r_frac);
        return res;
    endfunction

    // Driver: each accepted transfer is predicted with the current register value.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_ramps.push_back(voice_ramp(voice_t'(s_tdata[77:0]), stereo_mode));
                voices_sent <= voices_sent + 1;
                send_gap = gap_length();
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_voices.size() > 0) begin
                    s_tdata  <= {2'b00, pending_voices.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin
        ramp_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = ramp_t'(m_tdata[93:0]);
                ramps_seen <= ramps_seen + 1;
                if (expected_ramps.size() == 0) begin
                    $error("unexpected result transfer %h", got);
                    errors++;
                end else begin
                    want = expected_ramps.pop_front();
                    if (got.l_tgt !== want.l_tgt) begin
                        $error("left_target exp %0d got %0d", want.l_tgt, got.l_tgt); errors++;
                    end
                    if (got.r_tgt !== want.r_tgt) begin
                        $error("right_target exp %0d got %0d", want.r_tgt, got.r_tgt); errors++;
                    end
                    if (got.l_int !== want.l_int) begin
                        $error("left_rate_int exp %h got %h", want.l_int, got.l_int); errors++;
                    end
                    if (got.l_frac !== want.l_frac) begin
                        $error("left_rate_frac exp %h got %h", want.l_frac, got.l_frac);
                        errors++;
                    end
                    if (got.r_int !== want.r_int) begin
                        $error("right_rate_int exp %h got %h", want.r_int, got.r_int); errors++;
                    end
                    if (got.r_frac !== want.r_frac) begin
                        $error("right_rate_frac exp %h got %h", want.r_frac, got.r_frac);
                        errors++;
                    end
                end
            end
            // Receiver stalls: mostly short, sometimes long, with runs of none.
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap = gap_length();
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("** envelope_pan_ramp_setup_core: FAILED **");
            $finish;
        end
    end

    function automatic voice_t random_voice();
        voice_t v;
        int     pick;
        v.volume = 15'($urandom);
        v.pan    = 7'($urandom);
        v.cur_l  = 16'($urandom);
        v.cur_r  = 16'($urandom);
        pick = $urandom_range(0, 9);
        // Short segments reach saturation; long ones give small fractional rates.
        if (pick < 1) v.seg_len = 24'd0;
        else if (pick < 4) v.seg_len = 24'($urandom_range(1, 16));
        else if (pick < 7) v.seg_len = 24'($urandom_range(17, 4096));
        else v.seg_len = 24'($urandom);
        if ($urandom_range(0, 7) == 0) v.cur_l = 16'(v.volume >> 1);
        return v;
    endfunction

    function automatic voice_t make_voice(input int vol, input int p, input int cl, input int cr,
                                          input int seg);
        voice_t v;
        v.volume = 15'(vol); v.pan = 7'(p);
        v.cur_l = 16'(cl); v.cur_r = 16'(cr); v.seg_len = 24'(seg);
        return v;
    endfunction

    // Write the stereo register once the pipeline has fully drained.
    task automatic set_stereo(input logic value);
        wait (pending_voices.size() == 0 && !s_tvalid && expected_ramps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        stereo_mode = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_directed();
        pending_voices.push_back(make_voice(32767, 0, 0, 0, 0));           // zero length, up
        pending_voices.push_back(make_voice(0, 127, 32767, -32768, 0));    // zero length, left down, right up
        pending_voices.push_back(make_voice(0, 0, -32768, 0, 1));          // target and level clamps
        pending_voices.push_back(make_voice(32767, 64, 1, 1, 1));          // saturate high
        pending_voices.push_back(make_voice(0, 5, 32767, 32767, 1));       // saturate low
        pending_voices.push_back(make_voice(32767, 127, 32767, 0, 16777215));
        pending_voices.push_back(make_voice(12345, 63, 100, 20000, 3));
        pending_voices.push_back(make_voice(1, 1, -1, 2, 7));
        pending_voices.push_back(make_voice(32767, 0, 32767, 32767, 8));
        pending_voices.push_back(make_voice(20000, 100, 5000, 5000, 0));
    endtask

    initial begin
        int phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        load_directed();
        set_stereo(1'b1);
        load_directed();
        for (phase = 0; phase < 6; phase++) begin
            set_stereo(phase[0]);
            repeat (150) pending_voices.push_back(random_voice());
        end
        wait (pending_voices.size() == 0 && !s_tvalid && expected_ramps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d voices in mono and stereo, checked %0d results.",
                 voices_sent, ramps_seen);
        if (errors == 0 && expected_ramps.size() == 0) begin
            $display("** envelope_pan_ramp_setup_core: PASSED **");
        end else begin
            $display("** envelope_pan_ramp_setup_core: FAILED **");
        end
        $finish;
    end
endmodule
